### src/c2p_pkg.sv
`default_nettype none
package c2p_pkg;
  localparam int FRAC_BITS = 16;
  localparam int DATA_W    = 32;
  localparam int NUM_W     = DATA_W + FRAC_BITS;
  localparam int DENS_W    = 31;
  localparam int GAMMA_W   = 18;
  localparam int PROD_W    = 2 * DATA_W;
  localparam int SUM_W     = PROD_W + 2;
  localparam int KE_W      = SUM_W - (FRAC_BITS + 1);
  localparam int DIFF_W    = KE_W + 2;
  localparam int GP_W      = GAMMA_W + DENS_W;
  localparam int IN_W      = 5 * DATA_W;
  localparam int OUT_W     = 160;
  localparam int CFG_W     = 31;

  localparam logic [DENS_W-1:0] DIV100_M  = 31'd1374389535;
  localparam int                DIV100_SH = 37;
  localparam logic [DENS_W-1:0] POS_MAX   = {DENS_W{1'b1}};

  typedef enum logic {
    REG_GAMMA = 1'b0,
    REG_BASE  = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic [DENS_W-1:0]           dens;
    logic signed [DATA_W-1:0]    energy;
    logic                        dfix;
    logic [2:0]                  neg;
    logic [2:0][DATA_W-1:0]      mag;
  } side_t;

  typedef struct packed {
    logic [DENS_W-1:0]              dens;
    logic [2:0][DATA_W-1:0]         vel;
    logic                           dfix;
    logic                           dpos;
    logic [DENS_W-1:0]              diff;
    logic [DENS_W-1:0]              d100;
  } kin_t;
endpackage
`default_nettype wire

### src/conserved_to_primitive_hydro.sv
// A 48-stage radix-2 divider array forms the three velocities in parallel.
// Throughput: one cell per cycle; all stages advance together when the
// output register is empty or its result is taken.
// Reset (rst_n low at a clock edge) empties the pipeline and restores
// gamma_minus_one to 2/3 and base_density to 1.0.
`default_nettype none
module conserved_to_primitive_hydro import c2p_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  // density_in, mom_x, mom_y, mom_z, energy_in
  input  wire logic [IN_W-1:0]   in_tdata,
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  // density_out, vel_x, vel_y, vel_z, pressure_out, zero fill
  output logic [OUT_W-1:0]       out_tdata,
  // density_fixed, pressure_floored
  output logic [1:0]             out_tuser,
  input  wire logic              cfg_we,
  input  wire cfg_idx_t          cfg_idx,
  input  wire logic [CFG_W-1:0]  cfg_wdata
);
  logic [GAMMA_W-1:0]   gamma_r;
  logic [DENS_W-1:0]    base_r;
  logic                 en;
  side_t                side_in;
  logic                 div_valid;
  side_t                div_side;
  logic [2:0][NUM_W-1:0] div_quo;
  logic                 kin_valid;
  kin_t                 kin;
  logic                 vc_r;
  kin_t                 kin_c_r;
  logic [GP_W-1:0]      gp_c_r;
  logic                 out_valid_r;
  logic [OUT_W-1:0]     out_data_r;
  logic [1:0]           out_user_r;
  logic [OUT_W-1:0]     out_data_nxt;
  logic [1:0]           out_user_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gamma_r <= GAMMA_W'(43691);
      base_r  <= DENS_W'(65536);
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_GAMMA: gamma_r <= cfg_wdata[GAMMA_W-1:0];
        REG_BASE:  base_r  <= cfg_wdata[DENS_W-1:0];
        default:   ;
      endcase
    end
  end

  assign en        = !out_valid_r || out_tready;
  assign in_tready = en;

  always_comb begin
    logic signed [DATA_W-1:0] rho;
    logic signed [DATA_W-1:0] m;
    rho = in_tdata[DATA_W-1:0];
    side_in.energy = in_tdata[5*DATA_W-1:4*DATA_W];
    side_in.dfix   = (rho <= 0);
    if (rho <= 0) begin
      side_in.dens = (base_r == '0) ? DENS_W'(1) : base_r;
    end else begin
      side_in.dens = rho[DENS_W-1:0];
    end
    for (int l = 0; l < 3; l++) begin
      m = in_tdata[(l+2)*DATA_W-1 -: DATA_W];
      side_in.neg[l] = m[DATA_W-1];
      side_in.mag[l] = m[DATA_W-1] ? DATA_W'(-m) : DATA_W'(m);
    end
  end

  c2p_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_tvalid),
    .in_side   (side_in),
    .out_valid (div_valid),
    .out_side  (div_side),
    .out_quo   (div_quo)
  );

  c2p_kin u_kin (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (div_valid),
    .in_side   (div_side),
    .in_quo    (div_quo),
    .out_valid (kin_valid),
    .out_kin   (kin)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      vc_r        <= kin_valid;
      out_valid_r <= vc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      kin_c_r <= kin;
      gp_c_r  <= GP_W'(gamma_r) * GP_W'(kin.diff);
    end
  end

  always_comb begin
    logic [GP_W-FRAC_BITS-1:0] p;
    logic [DENS_W-1:0]         pres;
    logic                      flr;
    p    = gp_c_r[GP_W-1:FRAC_BITS];
    pres = (p > (GP_W-FRAC_BITS)'(POS_MAX)) ? POS_MAX : p[DENS_W-1:0];
    flr  = !kin_c_r.dpos || (pres == '0);
    if (flr) begin
      pres = kin_c_r.d100;
    end
    out_data_nxt = {2'b00, pres, kin_c_r.vel[2], kin_c_r.vel[1], kin_c_r.vel[0],
                    kin_c_r.dens};
    out_user_nxt = {flr, kin_c_r.dfix};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= out_data_nxt;
      out_user_r <= out_user_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
endmodule
`default_nettype wire

### src/c2p_div.sv
`default_nettype none
module c2p_div import c2p_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   en,
  input  wire logic                   in_valid,
  input  wire side_t                  in_side,
  output logic                        out_valid,
  output side_t                       out_side,
  output logic [2:0][NUM_W-1:0]       out_quo
);
  logic [NUM_W:0]                vld_r;
  side_t                         side_r [NUM_W+1];
  logic [2:0][DENS_W-1:0]        rem_r  [NUM_W+1];
  logic [2:0][NUM_W-1:0]         nq_r   [NUM_W+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= in_side;
      for (int l = 0; l < 3; l++) begin
        rem_r[0][l] <= '0;
        nq_r[0][l]  <= {in_side.mag[l], {FRAC_BITS{1'b0}}};
      end
    end
  end

  for (genvar s = 0; s < NUM_W; s++) begin : g_stage
    logic [2:0][DENS_W-1:0] rem_nxt;
    logic [2:0][NUM_W-1:0]  nq_nxt;

    always_comb begin
      logic [DENS_W:0] t;
      logic            ge;
      for (int l = 0; l < 3; l++) begin
        t  = {rem_r[s][l], nq_r[s][l][NUM_W-1]};
        ge = (t >= {1'b0, side_r[s].dens});
        rem_nxt[l] = ge ? DENS_W'(t - {1'b0, side_r[s].dens}) : t[DENS_W-1:0];
        nq_nxt[l]  = {nq_r[s][l][NUM_W-2:0], ge};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s+1] <= 1'b0;
      end else if (en) begin
        vld_r[s+1] <= vld_r[s];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        side_r[s+1] <= side_r[s];
        rem_r[s+1]  <= rem_nxt;
        nq_r[s+1]   <= nq_nxt;
      end
    end
  end

  assign out_valid = vld_r[NUM_W];
  assign out_side  = side_r[NUM_W];
  assign out_quo   = nq_r[NUM_W];
endmodule
`default_nettype wire

### src/c2p_kin.sv
`default_nettype none
module c2p_kin import c2p_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   en,
  input  wire logic                   in_valid,
  input  wire side_t                  in_side,
  input  wire logic [2:0][NUM_W-1:0]  in_quo,
  output logic                        out_valid,
  output kin_t                        out_kin
);
  logic                       va_r;
  logic [DENS_W-1:0]          dens_a_r;
  logic signed [DATA_W-1:0]   energy_a_r;
  logic                       dfix_a_r;
  logic [2:0][DATA_W-1:0]     vel_a_r;
  logic [2:0][PROD_W-1:0]     prod_a_r;
  logic [2*DENS_W-1:0]        d100_a_r;
  logic [2:0][DATA_W-1:0]     vel_nxt;
  logic [2:0][DATA_W-1:0]     vmag_nxt;
  logic                       vb_r;
  kin_t                       kin_r;
  kin_t                       kin_nxt;

  always_comb begin
    logic [NUM_W-1:0] lim;
    for (int l = 0; l < 3; l++) begin
      lim = in_side.neg[l] ? NUM_W'({1'b1, {(DATA_W-1){1'b0}}})
                           : NUM_W'({1'b0, {(DATA_W-1){1'b1}}});
      vmag_nxt[l] = (in_quo[l] > lim) ? lim[DATA_W-1:0] : in_quo[l][DATA_W-1:0];
      vel_nxt[l]  = in_side.neg[l] ? DATA_W'(-vmag_nxt[l]) : vmag_nxt[l];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else if (en) begin
      va_r <= in_valid;
      vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dens_a_r   <= in_side.dens;
      energy_a_r <= in_side.energy;
      dfix_a_r   <= in_side.dfix;
      vel_a_r    <= vel_nxt;
      for (int l = 0; l < 3; l++) begin
        prod_a_r[l] <= PROD_W'(in_side.mag[l]) * PROD_W'(vmag_nxt[l]);
      end
      d100_a_r <= (2*DENS_W)'(in_side.dens) * (2*DENS_W)'(DIV100_M);
    end
  end

  always_comb begin
    logic [SUM_W-1:0]         sum;
    logic [KE_W-1:0]          ke;
    logic signed [DIFF_W-1:0] diff;
    sum  = SUM_W'(prod_a_r[0]) + SUM_W'(prod_a_r[1]) + SUM_W'(prod_a_r[2]);
    ke   = sum[SUM_W-1:FRAC_BITS+1];
    diff = DIFF_W'(energy_a_r) - $signed({2'b00, ke});
    kin_nxt.dens = dens_a_r;
    kin_nxt.vel  = vel_a_r;
    kin_nxt.dfix = dfix_a_r;
    kin_nxt.dpos = !diff[DIFF_W-1] && (diff != '0);
    kin_nxt.diff = diff[DENS_W-1:0];
    kin_nxt.d100 = DENS_W'(d100_a_r >> DIV100_SH);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      kin_r <= kin_nxt;
    end
  end

  assign out_valid = vb_r;
  assign out_kin   = kin_r;
endmodule
`default_nettype wire

### tb/conserved_to_primitive_hydro_tb.sv
`timescale 1ns / 1ps
module conserved_to_primitive_hydro_tb;
  import c2p_pkg::*;

  typedef struct packed {
    logic [30:0] dens;
    logic [31:0] vx;
    logic [31:0] vy;
    logic [31:0] vz;
    logic [30:0] pres;
    logic        dfix;
    logic        pflr;
  } prim_t;

  class prim_scoreboard;
    logic [17:0] gamma_m1;
    logic [30:0] base_dens;
    prim_t       pending[$];
    int          errors;

    function new();
      gamma_m1  = 18'd43691;
      base_dens = 31'd65536;
      errors    = 0;
    endfunction

    function automatic logic signed [63:0] velocity(logic signed [63:0] mom,
                                                     logic [63:0] dens);
      logic [63:0] mag;
      logic [63:0] q;
      mag = (mom < 0) ? -mom : mom;
      q = (mag << FRAC_BITS) / dens;
      if (mom < 0) begin
        if (q >= 64'h8000_0000) return -64'sh8000_0000;
        return -$signed(q);
      end
      if (q > 64'h7FFF_FFFF) return 64'sh7FFF_FFFF;
      return $signed(q);
    endfunction

    function void note_cell(logic [159:0] d);
      logic signed [63:0] rho, energy, diff;
      logic signed [63:0] mom[3];
      logic signed [63:0] vel[3];
      logic [63:0] dens, ksum, pres, a, b;
      prim_t r;
      rho    = $signed(d[31:0]);
      energy = $signed(d[159:128]);
      for (int i = 0; i < 3; i++) mom[i] = $signed(d[32*(i+1) +: 32]);
      r.dfix = 1'b0;
      if (rho <= 0) begin
        dens = (base_dens == 0) ? 64'd1 : {33'd0, base_dens};
        r.dfix = 1'b1;
      end else begin
        dens = rho;
      end
      ksum = 0;
      for (int i = 0; i < 3; i++) begin
        vel[i] = velocity(mom[i], dens);
        a = (mom[i] < 0) ? -mom[i] : mom[i];
        b = (vel[i] < 0) ? -vel[i] : vel[i];
        ksum += a * b;
      end
      diff = energy - $signed(ksum >> (FRAC_BITS + 1));
      pres = 0;
      if (diff > 0) begin
        pres = ({46'd0, gamma_m1} * diff) >> FRAC_BITS;
        if (pres > 64'h7FFF_FFFF) pres = 64'h7FFF_FFFF;
      end
      r.pflr = 1'b0;
      if (pres == 0) begin
        pres = dens / 100;
        r.pflr = 1'b1;
      end
      r.dens = dens[30:0];
      r.vx = vel[0][31:0];
      r.vy = vel[1][31:0];
      r.vz = vel[2][31:0];
      r.pres = pres[30:0];
      pending.push_back(r);
    endfunction

    function void check_result(logic [159:0] d, logic [1:0] u);
      prim_t e, g;
      g = {d[30:0], d[62:31], d[94:63], d[126:95], d[157:127], u[0], u[1]};
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %h", $time, g);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (g !== e) begin
        $display("%0t: mismatch expected dens=%h v=%h %h %h p=%h df=%b pf=%b",
                 $time, e.dens, e.vx, e.vy, e.vz, e.pres, e.dfix, e.pflr);
        $display("%0t:          actual   dens=%h v=%h %h %h p=%h df=%b pf=%b",
                 $time, g.dens, g.vx, g.vy, g.vz, g.pres, g.dfix, g.pflr);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;
  logic [1:0] out_tuser;
  logic cfg_we = 1'b0;
  cfg_idx_t cfg_idx = REG_GAMMA;
  logic [CFG_W-1:0] cfg_wdata = '0;

  prim_scoreboard sb = new();
  bit calm = 1'b0;
  longint cycles = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  conserved_to_primitive_hydro u_top (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("CHECK FAILED");
      $finish;
    end
    if (rst_n && in_tvalid && in_tready) sb.note_cell(in_tdata);
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata, out_tuser);
  end

  initial begin
    int n;
    @(posedge clk);
    forever begin
      if (!calm && $urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        n = $urandom_range(1, 10);
        repeat (n) @(posedge clk);
      end
      out_tready <= 1'b1;
      n = $urandom_range(1, 10);
      repeat (n) @(posedge clk);
    end
  end

  task automatic send_cell(logic [31:0] rho, logic [31:0] mx, logic [31:0] my,
                           logic [31:0] mz, logic [31:0] en);
    int n;
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      n = $urandom_range(1, 10);
      repeat (n) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {en, mz, my, mx, rho};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [30:0] val);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    if (idx == REG_GAMMA) sb.gamma_m1 = val[17:0];
    else sb.base_dens = val;
    @(posedge clk);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  function automatic logic [31:0] rnd_val();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return $urandom_range(0, 32'h0010_0000);
      2: return -$urandom_range(0, 32'h0010_0000);
      3: return $urandom_range(0, 32'h00FF_FFFF);
      4: return {1'b1, 31'($urandom())};
      default: return $urandom_range(0, 32'h7FFF);
    endcase
  endfunction

  task automatic random_cells(int count);
    logic [31:0] rho;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(0, 9))
        0: rho = 32'($signed(-$urandom_range(0, 100)));
        1: rho = $urandom();
        2: rho = $urandom_range(1, 200);
        default: rho = $urandom_range(32'h0000_1000, 32'h0100_0000);
      endcase
      send_cell(rho, rnd_val(), rnd_val(), rnd_val(), rnd_val());
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_cell(32'h0001_0000, 32'h0002_0000, 32'hFFFE_0000, 32'h0, 32'h0010_0000);
    send_cell(32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h1, 32'h7FFF_FFFF);
    send_cell(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
              32'h8000_0000);
    send_cell(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
              32'h7FFF_FFFF);
    send_cell(32'h1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h1, 32'h0);
    send_cell(32'h0000_0050, 32'h0, 32'h0, 32'h0, 32'hFFFF_FFFF);
    send_cell(32'h0001_0000, 32'h0, 32'h0, 32'h0, 32'h1);
    send_cell(32'h0001_0000, 32'h0001_0000, 32'h0, 32'h0, 32'h0000_8000);
    send_cell(32'hFFFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA, 32'h0, 32'h5555_5555);
    drain();
    write_reg(REG_GAMMA, 31'd0);
    write_reg(REG_BASE, 31'd0);
    send_cell(32'h0, 32'h0001_0000, 32'h0, 32'h0, 32'h7FFF_FFFF);
    send_cell(32'h0064_0000, 32'h0, 32'h0, 32'h0, 32'h7FFF_FFFF);
    random_cells(200);
    drain();
    write_reg(REG_GAMMA, 31'd131072);
    write_reg(REG_BASE, 31'h7FFF_FFFF);
    send_cell(32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h7FFF_FFFF);
    random_cells(300);
    drain();
    write_reg(REG_GAMMA, 31'h3FFFF);
    write_reg(REG_BASE, 31'd99);
    random_cells(300);
    drain();
    write_reg(REG_GAMMA, 31'd6554);
    write_reg(REG_BASE, 31'd1);
    random_cells(300);
    drain();
    for (int k = 0; k < 3; k++) begin
      write_reg(REG_GAMMA, 31'($urandom_range(0, 131072)));
      write_reg(REG_BASE, 31'($urandom()));
      random_cells(250);
      drain();
    end
    write_reg(REG_GAMMA, 31'd43691);
    write_reg(REG_BASE, 31'd65536);
    calm = 1'b1;
    random_cells(150);
    drain();
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule

### files.f
src/c2p_pkg.sv
src/c2p_div.sv
src/c2p_kin.sv
src/conserved_to_primitive_hydro.sv
tb/conserved_to_primitive_hydro_tb.sv
